// ===== hdl/affine_2d_transform_unit_core_assert.svh =====
// Assertion macros shared by the affine transform unit RTL.
`ifndef AFFINE_2D_TRANSFORM_UNIT_CORE_ASSERT_SVH
`define AFFINE_2D_TRANSFORM_UNIT_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define AFF2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define AFF2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/aff2d_pkg.sv =====
// Shared constants, types and helper functions of the affine transform unit.
package aff2d_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_RUNS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = (CORDIC_RUNS > 1) ? $clog2(CORDIC_RUNS) : 1;
    localparam int ATAN_IDX_W   = 5;

    localparam int DATA_W  = 32;
    localparam int ANGLE_W = 16;
    localparam int OPQ_W   = DATA_W + 1;
    localparam int PROD_W  = DATA_W + OPQ_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int CRD_W   = 34;
    localparam int Z_W     = 35;

    localparam int ANGLE_SHIFT = 17;
    localparam int OUT_SHIFT   = 30 - FRAC_BITS;

    localparam logic signed [DATA_W-1:0] FIX_ONE     = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [CRD_W-1:0]  CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Z_W-1:0]    HALF_PI     = 35'sd1686629713;
    localparam logic signed [Z_W-1:0]    FULL_PI     = 35'sd3373259426;

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_IDENTITY  = 3'd0,
        CMD_TRANSLATE = 3'd1,
        CMD_ROTATE    = 3'd2,
        CMD_SCALE     = 3'd3,
        CMD_TRANSFORM = 3'd4
    } cmd_t;

    // Matrix coefficient slots
    typedef logic [2:0] coef_idx_t;
    localparam coef_idx_t COEF_A  = 3'd0;
    localparam coef_idx_t COEF_B  = 3'd1;
    localparam coef_idx_t COEF_C  = 3'd2;
    localparam coef_idx_t COEF_D  = 3'd3;
    localparam coef_idx_t COEF_TX = 3'd4;
    localparam coef_idx_t COEF_TY = 3'd5;

    typedef enum logic [2:0] {
        Q_OX,
        Q_OY,
        Q_CS,
        Q_SN,
        Q_NSN
    } qsel_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_FIRST,
        MAC_NEXT
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
        logic    add_en;
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT_WAIT,
        S_MUL0,
        S_MUL1,
        S_FIN,
        S_COMMIT
    } state_t;

    // One output coefficient: up to two products plus an optional addend
    typedef struct packed {
        coef_idx_t p0;
        qsel_t     q0;
        logic      two;
        coef_idx_t p1;
        qsel_t     q1;
        logic      add_en;
        coef_idx_t add_idx;
        coef_idx_t dst;
    } term_t;

    function automatic term_t term_decode(input logic [2:0] cmd, input logic [1:0] idx);
        term_t t;
        t = '0;
        case (cmd)
            CMD_TRANSLATE, CMD_TRANSFORM:
            begin
                t.two    = 1'b1;
                t.add_en = 1'b1;
                t.q0     = Q_OX;
                t.q1     = Q_OY;
                if (idx[0] == 1'b0)
                begin
                    t.p0      = COEF_A;
                    t.p1      = COEF_C;
                    t.add_idx = COEF_TX;
                    t.dst     = COEF_TX;
                end
                else
                begin
                    t.p0      = COEF_B;
                    t.p1      = COEF_D;
                    t.add_idx = COEF_TY;
                    t.dst     = COEF_TY;
                end
            end
            CMD_ROTATE:
            begin
                t.two = 1'b1;
                t.p0  = idx[1] ? COEF_B : COEF_A;
                t.p1  = idx[1] ? COEF_D : COEF_C;
                t.q0  = idx[0] ? Q_NSN : Q_CS;
                t.q1  = idx[0] ? Q_CS : Q_SN;
                case (idx)
                    2'd0:    t.dst = COEF_A;
                    2'd1:    t.dst = COEF_C;
                    2'd2:    t.dst = COEF_B;
                    default: t.dst = COEF_D;
                endcase
            end
            CMD_SCALE:
            begin
                case (idx)
                    2'd0:    t.p0 = COEF_A;
                    2'd1:    t.p0 = COEF_B;
                    2'd2:    t.p0 = COEF_C;
                    default: t.p0 = COEF_D;
                endcase
                t.q0  = idx[1] ? Q_OY : Q_OX;
                t.dst = t.p0;
            end
            default:
            begin
                t = '0;
            end
        endcase
        return t;
    endfunction

    // Index of the final output coefficient for a command
    function automatic logic [1:0] last_term(input logic [2:0] cmd);
        logic [1:0] r;
        case (cmd)
            CMD_ROTATE, CMD_SCALE: r = 2'd3;
            CMD_TRANSLATE, CMD_TRANSFORM: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Truncated arctangent of 2^-i in Q2.30
    function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h3243F6A8;
            5'd1:    r = 32'h1DAC6705;
            5'd2:    r = 32'h0FADBAFC;
            5'd3:    r = 32'h07F56EA6;
            5'd4:    r = 32'h03FEAB76;
            5'd5:    r = 32'h01FFD55B;
            5'd6:    r = 32'h00FFFAAA;
            5'd7:    r = 32'h007FFF55;
            5'd8:    r = 32'h003FFFEA;
            5'd9:    r = 32'h001FFFFD;
            5'd10:   r = 32'h000FFFFF;
            5'd11:   r = 32'h0007FFFF;
            5'd12:   r = 32'h0003FFFF;
            5'd13:   r = 32'h0001FFFF;
            5'd14:   r = 32'h0000FFFF;
            5'd15:   r = 32'h00007FFF;
            5'd16:   r = 32'h00003FFF;
            5'd17:   r = 32'h00001FFF;
            5'd18:   r = 32'h00000FFF;
            5'd19:   r = 32'h000007FF;
            5'd20:   r = 32'h000003FF;
            5'd21:   r = 32'h000001FF;
            5'd22:   r = 32'h000000FF;
            5'd23:   r = 32'h0000007F;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[DATA_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/aff2d_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module aff2d_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [aff2d_pkg::ANGLE_W-1:0] angle,
    output logic                                 done,
    output logic signed [aff2d_pkg::DATA_W-1:0]  cos_out,
    output logic signed [aff2d_pkg::DATA_W-1:0]  sin_out
);
    import aff2d_pkg::*;

    logic                     run_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [CRD_W-1:0]  x_reg;
    logic signed [CRD_W-1:0]  y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic                     flip_reg;
    logic signed [DATA_W-1:0] cos_reg;
    logic signed [DATA_W-1:0] sin_reg;

    logic signed [Z_W-1:0]    z_wide;
    logic signed [Z_W-1:0]    z_init;
    logic                     flip_init;
    logic signed [Z_W-1:0]    atan_z;
    logic signed [CRD_W-1:0]  x_sh;
    logic signed [CRD_W-1:0]  y_sh;
    logic signed [CRD_W-1:0]  x_fl;
    logic signed [CRD_W-1:0]  y_fl;
    logic signed [CRD_W-1:0]  x_fix;
    logic signed [CRD_W-1:0]  y_fix;
    logic                     last_step;

    // Widen the angle to Q2.30 and fold it into minus half pi to half pi
    always_comb
    begin
        z_wide    = Z_W'(angle) <<< ANGLE_SHIFT;
        z_init    = z_wide;
        flip_init = 1'b0;
        if (z_wide > HALF_PI)
        begin
            z_init    = z_wide - FULL_PI;
            flip_init = 1'b1;
        end
        else if (z_wide < -HALF_PI)
        begin
            z_init    = z_wide + FULL_PI;
            flip_init = 1'b1;
        end
    end

    // Micro-rotation operands
    assign atan_z    = signed'({{(Z_W-32){1'b0}}, atan_q30(ATAN_IDX_W'(step_reg))});
    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign last_step = (step_reg == STEP_W'(CORDIC_RUNS - 1));

    // Scale down to the matrix format and undo the fold
    assign x_fl  = x_reg >>> OUT_SHIFT;
    assign y_fl  = y_reg >>> OUT_SHIFT;
    assign x_fix = flip_reg ? -x_fl : x_fl;
    assign y_fix = flip_reg ? -y_fl : y_fl;

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= !start && run_reg && last_step;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (last_step)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // Rotate the vector one step per cycle, then latch cosine and sine
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip_init;
        end
        else if (run_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_z;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_z;
            end
        end
        if (fin_reg)
        begin
            cos_reg <= sat32(ACC_W'(x_fix));
            sin_reg <= sat32(ACC_W'(y_fix));
        end
    end

    assign done    = done_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// ===== hdl/aff2d_mac.sv =====
// Shared multiply-accumulate unit with floor rounding and 32-bit saturation.
module aff2d_mac (
    input  logic                                clk,
    input  aff2d_pkg::mac_ctrl_t                ctrl,
    input  logic signed [aff2d_pkg::DATA_W-1:0] p,
    input  logic signed [aff2d_pkg::OPQ_W-1:0]  q,
    input  logic signed [aff2d_pkg::DATA_W-1:0] addend,
    output logic signed [aff2d_pkg::DATA_W-1:0] result
);
    import aff2d_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] product;
    logic signed [ACC_W-1:0]  prod_fl;
    logic signed [ACC_W-1:0]  add_wide;

    // Exact product, then floor shift of the registered one
    assign product  = p * q;
    assign prod_fl  = ACC_W'(prod_reg >>> FRAC_BITS);
    assign add_wide = ctrl.add_en ? ACC_W'(addend) : '0;

    // Register the product; fold the previous one into the accumulator
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            MAC_FIRST:
            begin
                prod_reg <= product;
                acc_reg  <= '0;
            end
            MAC_NEXT:
            begin
                prod_reg <= product;
                acc_reg  <= prod_fl + add_wide;
            end
            default:
            begin
                prod_reg <= prod_reg;
                acc_reg  <= acc_reg;
            end
        endcase
    end

    // Final sum with the last product, clamped
    assign result = sat32(acc_reg + prod_fl);

endmodule

// ===== hdl/affine_2d_transform_unit_core.sv =====
// Top level of the affine transform unit: sequencer, matrix registers, output beat.
// A new beat is taken only in S_IDLE; identity is done on acceptance. Other commands
// run each output coefficient through the shared multiplier in S_MUL0, S_MUL1 (two
// products only) and S_FIN; rotate first waits in S_ROT_WAIT, one CORDIC step per cycle.
// A transform result is loaded into the output register in S_FIN once that register is free.
// Reset sets the matrix to identity and empties the output register.
`include "affine_2d_transform_unit_core_assert.svh"

module affine_2d_transform_unit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           command,
    input  logic signed [aff2d_pkg::DATA_W-1:0]  operand_x,
    input  logic signed [aff2d_pkg::DATA_W-1:0]  operand_y,
    input  logic signed [aff2d_pkg::ANGLE_W-1:0] angle,
    input  logic                                 last_vertex,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [aff2d_pkg::DATA_W-1:0]  out_x,
    output logic signed [aff2d_pkg::DATA_W-1:0]  out_y,
    output logic                                 last_of_batch
);
    import aff2d_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    logic [2:0]               cmd_reg;
    logic signed [DATA_W-1:0] ox_reg;
    logic signed [DATA_W-1:0] oy_reg;
    logic                     last_reg;
    logic [1:0]               idx_reg;
    logic signed [DATA_W-1:0] coef_reg [6];
    logic signed [DATA_W-1:0] work_reg [6];
    logic signed [DATA_W-1:0] xhold_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_x_reg;
    logic signed [DATA_W-1:0] out_y_reg;
    logic                     out_last_reg;

    logic                     accept;
    logic                     cordic_start;
    logic                     cordic_done;
    logic signed [DATA_W-1:0] cos_val;
    logic signed [DATA_W-1:0] sin_val;
    term_t                    term;
    logic [1:0]               last_idx;
    logic                     fin_last;
    logic                     is_xform;
    logic                     out_free;
    logic                     out_load;
    mac_ctrl_t                mac_ctrl;
    coef_idx_t                p_idx;
    qsel_t                    q_sel;
    logic signed [OPQ_W-1:0]  q_val;
    logic signed [DATA_W-1:0] mac_result;
    logic                     ident_beat;
    logic                     unit_matrix;
    logic                     xform_fin;

    assign accept   = in_valid && !in_stall;
    assign term     = term_decode(cmd_reg, idx_reg);
    assign last_idx = last_term(cmd_reg);
    assign fin_last = (idx_reg == last_idx);
    assign is_xform = (cmd_reg == CMD_TRANSFORM);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_FIN) && is_xform && fin_last && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_TRANSLATE, CMD_SCALE, CMD_TRANSFORM: state_next = S_MUL0;
                        CMD_ROTATE: state_next = S_ROT_WAIT;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ROT_WAIT:
            begin
                if (cordic_done)
                    state_next = S_MUL0;
            end
            S_MUL0:
            begin
                state_next = term.two ? S_MUL1 : S_FIN;
            end
            S_MUL1:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!fin_last)
                    state_next = S_MUL0;
                else if (!is_xform)
                    state_next = S_COMMIT;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        in_stall        = (state_reg != S_IDLE);
        cordic_start    = 1'b0;
        mac_ctrl.op     = MAC_HOLD;
        mac_ctrl.add_en = term.add_en;
        p_idx           = term.p0;
        q_sel           = term.q0;
        case (state_reg)
            S_IDLE:
            begin
                cordic_start = accept && (command == CMD_ROTATE);
            end
            S_MUL0:
            begin
                mac_ctrl.op = MAC_FIRST;
            end
            S_MUL1:
            begin
                mac_ctrl.op = MAC_NEXT;
                p_idx       = term.p1;
                q_sel       = term.q1;
            end
            default:
            begin
                mac_ctrl.op = MAC_HOLD;
            end
        endcase
    end

    // Select the multiplier operand
    always_comb
    begin
        case (q_sel)
            Q_OX:    q_val = OPQ_W'(ox_reg);
            Q_OY:    q_val = OPQ_W'(oy_reg);
            Q_CS:    q_val = OPQ_W'(cos_val);
            Q_SN:    q_val = OPQ_W'(sin_val);
            Q_NSN:   q_val = -OPQ_W'(sin_val);
            default: q_val = '0;
        endcase
    end

    aff2d_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (angle),
        .done    (cordic_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    aff2d_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .p      (coef_reg[p_idx]),
        .q      (q_val),
        .addend (work_reg[term.add_idx]),
        .result (mac_result)
    );

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                idx_reg <= '0;
            else if ((state_reg == S_FIN) && !fin_last)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // Hold the operands of the accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            ox_reg   <= operand_x;
            oy_reg   <= operand_y;
            last_reg <= last_vertex;
        end
    end

    // Matrix: load identity, or commit the updated working copy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[COEF_A]  <= FIX_ONE;
            coef_reg[COEF_B]  <= '0;
            coef_reg[COEF_C]  <= '0;
            coef_reg[COEF_D]  <= FIX_ONE;
            coef_reg[COEF_TX] <= '0;
            coef_reg[COEF_TY] <= '0;
        end
        else if (accept && (command == CMD_IDENTITY))
        begin
            coef_reg[COEF_A]  <= FIX_ONE;
            coef_reg[COEF_B]  <= '0;
            coef_reg[COEF_C]  <= '0;
            coef_reg[COEF_D]  <= FIX_ONE;
            coef_reg[COEF_TX] <= '0;
            coef_reg[COEF_TY] <= '0;
        end
        else if (state_reg == S_COMMIT)
        begin
            coef_reg <= work_reg;
        end
    end

    // Working copy takes new coefficients as they finish
    always_ff @(posedge clk)
    begin
        if (accept)
            work_reg <= coef_reg;
        else if ((state_reg == S_FIN) && !is_xform)
            work_reg[term.dst] <= mac_result;
        if ((state_reg == S_FIN) && is_xform && (idx_reg == 2'd0))
            xhold_reg <= mac_result;
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg    <= xhold_reg;
            out_y_reg    <= mac_result;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign last_of_batch = out_last_reg;

    // Terms watched by the checks below
    assign ident_beat  = accept && (command == CMD_IDENTITY);
    assign unit_matrix = (coef_reg[COEF_A] == FIX_ONE) && (coef_reg[COEF_B] == '0) &&
                         (coef_reg[COEF_TX] == '0);
    assign xform_fin   = (state_reg == S_FIN) && is_xform;

    `AFF2D_ASSERT_NEXT(a_identity_load, ident_beat, unit_matrix, "identity left no unit matrix")
    `AFF2D_ASSERT_NOW(a_cordic_done_wait, cordic_done, state_reg == S_ROT_WAIT, "CORDIC done early")
    `AFF2D_ASSERT_NOW(a_out_from_xform, $rose(out_valid_reg), $past(xform_fin), "stray out beat")
    `AFF2D_ASSERT_NEXT(a_commit_to_idle, state_reg == S_COMMIT, !in_stall, "commit did not idle")

endmodule
